[hw/rtl/pfs_pkg.sv]
// ----------------------------------------------------------------------------
// pfs_pkg: shared constants for the profiled fps frequency selector
// Field widths, register indexes, command codes, fixed-point constants and reset values.
// ----------------------------------------------------------------------------
package pfs_pkg;

	// Default number of frequency levels
	localparam int LEVELS_DEF = 32;

	// Field widths
	localparam int FT_W   = 24;   // frame time, us
	localparam int FPS_W  = 18;   // Q8 rate
	localparam int SPL_W  = 10;   // samples per level
	localparam int NLV_W  = 6;    // num_levels register
	localparam int LVL_W  = 5;    // freq_level output
	localparam int SUM_W  = 34;   // saturating time sum
	localparam int NUM_W  = 38;   // samples * scale
	localparam int QUO_W  = FPS_W + 1;
	localparam int DSH_W  = SUM_W + FPS_W;

	// Configuration register indexes
	localparam int CFG_AW = 2;
	localparam logic [CFG_AW-1:0] CFG_ENABLE    = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_SAMPLES   = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_NUM_LVL   = 2'd2;
	localparam logic [CFG_AW-1:0] CFG_THRESHOLD = 2'd3;

	// Input command codes
	localparam logic CMD_FRAME  = 1'b0;
	localparam logic CMD_TARGET = 1'b1;

	// Fixed-point constants
	localparam logic [27:0]      Q8_SCALE = 28'd256000000;
	localparam logic [FPS_W-1:0] FPS_MAX  = '1;
	localparam logic [SUM_W-1:0] SUM_MAX  = '1;

	// Register reset values
	localparam logic [SPL_W-1:0] SAMPLES_RST   = 10'd16;
	localparam logic [NLV_W-1:0] NUM_LVL_RST   = 6'd32;
	localparam logic [FPS_W-1:0] THRESHOLD_RST = 18'd256;

endpackage

[hw/rtl/profiled_fps_frequency_selector.sv]
// ----------------------------------------------------------------------------
// profiled_fps_frequency_selector
// Frame-rate governor: profiles the rate of each configured frequency level, then picks
// the level whose profiled rate is nearest to a requested target.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Bits                     Transfer when
// s_axis    in   tuser: command           s_tvalid & s_tready
//                tdata: frame_time_us, target_fps
// m_axis    out  tdata: result flags      m_tvalid & m_tready
// cfg       in   cfg_addr, cfg_wdata      cfg_we
//
// One item at a time; s_tready is high only while the sequencer is idle.
// A frame item without a finished window is decoded and output. A frame that
// closes a window adds one multiply and 19 restoring-divide steps on a shared
// 52-bit compare/subtract. A target scan covers n levels, one table read per
// cycle. A held result stalls only the final step; the next
// item may be accepted while the result waits. The table has no clearing pass.
// ----------------------------------------------------------------------------

module profiled_fps_frequency_selector
	import pfs_pkg::*;
#(
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [47:0]        s_tdata,   // [23:0] frame_time_us, [41:24] target_fps
	input  logic               s_tuser,   // [0] command
	// result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,   // [4:0] freq_level, [5] freq_changed,
	                                      // [23:6] fps_value, [24] fps_valid,
	                                      // [25] profiling_done,
	                                      // [26] target_out_of_range, [27] target_met
	// configuration
	input  logic               cfg_we,
	input  logic [CFG_AW-1:0]  cfg_addr,
	input  logic [FPS_W-1:0]   cfg_wdata
);

	localparam int IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int CW = $clog2(LEVELS + 1);
	localparam logic [31:0] LEVELS_U = 32'(LEVELS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_MUL, ST_DIV, ST_DIVEND,
		ST_SCAN, ST_SCANEND, ST_DECIDE, ST_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic             enable_q;
	logic [SPL_W-1:0] samples_q;
	logic [NLV_W-1:0] num_lvl_q;
	logic [FPS_W-1:0] threshold_q;

	// captured item
	logic             cmd_q;
	logic [FT_W-1:0]  ft_q;
	logic [FPS_W-1:0] tgt_q;

	// governor state
	logic [CW-1:0]    profile_q;
	logic [SPL_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [FPS_W-1:0] current_q;
	logic [FPS_W-1:0] last_tgt_q;
	logic             done_q;
	logic [IW-1:0]    applied_q;

	// divider
	logic [NUM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [4:0]       step_q;

	// scan
	logic [IW-1:0]    scan_q;
	logic [IW-1:0]    cmp_idx_q;
	logic             cmp_vld_q;
	logic [FPS_W-1:0] min_err_q;
	logic [IW-1:0]    best_q;
	logic             retune_q;

	// per-item result
	logic             res_changed_q;
	logic [FPS_W-1:0] res_fps_q;
	logic             res_valid_q;
	logic             res_oor_q;
	logic             res_met_q;

	// result register
	logic             m_valid_q;
	logic [31:0]      m_data_q;

	// fps table
	logic [FPS_W-1:0] tbl_mem [LEVELS];
	logic [FPS_W-1:0] rd_q;
	logic             tbl_we;
	logic [FPS_W-1:0] fps_div;

	// effective sample and level counts
	logic [SPL_W-1:0] s_eff;
	logic [CW-1:0]    n_eff;
	logic [IW-1:0]    n_last;
	logic [31:0]      num32;

	assign s_eff  = (samples_q == '0) ? SPL_W'(1) : samples_q;
	assign num32  = {{(32-NLV_W){1'b0}}, num_lvl_q};
	always_comb begin
		if (num_lvl_q == '0) begin
			n_eff = CW'(1);
		end else if (num32 > LEVELS_U) begin
			n_eff = CW'(LEVELS);
		end else begin
			n_eff = CW'(num32);
		end
	end
	assign n_last = IW'(n_eff - CW'(1));

	// saturating accumulate and window test
	logic [SUM_W:0]   sum_add;
	logic [SUM_W-1:0] sum_new;
	logic             win_end;

	assign sum_add = {1'b0, sum_q} + {{(SUM_W+1-FT_W){1'b0}}, ft_q};
	assign sum_new = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
	assign win_end = ({1'b0, count_q} + (SPL_W+1)'(1)) >= {1'b0, s_eff};

	// numerator multiply
	logic [NUM_W-1:0] prod;
	assign prod = {{(NUM_W-SPL_W){1'b0}}, s_eff} * {{(NUM_W-28){1'b0}}, Q8_SCALE};

	// shared compare/subtract step of the divider
	logic div_ge;
	assign div_ge = {{(DSH_W-NUM_W){1'b0}}, rem_q} >= dsh_q;

	assign fps_div = quo_q[QUO_W-1] ? FPS_MAX : quo_q[FPS_W-1:0];

	// absolute errors
	logic [FPS_W-1:0] cur_err;
	logic [FPS_W-1:0] scan_err;
	assign cur_err  = (tgt_q > current_q) ? tgt_q - current_q : current_q - tgt_q;
	assign scan_err = (tgt_q > rd_q) ? tgt_q - rd_q : rd_q - tgt_q;

	// table write when a profiling window closes
	assign tbl_we = (state_q == ST_DIVEND) && !done_q;

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[profile_q[IW-1:0]] <= fps_div;
		end
		rd_q <= tbl_mem[scan_q];
	end

	// handshakes
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			samples_q   <= SAMPLES_RST;
			num_lvl_q   <= NUM_LVL_RST;
			threshold_q <= THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ENABLE:    enable_q    <= cfg_wdata[0];
				CFG_SAMPLES:   samples_q   <= cfg_wdata[SPL_W-1:0];
				CFG_NUM_LVL:   num_lvl_q   <= cfg_wdata[NLV_W-1:0];
				CFG_THRESHOLD: threshold_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			profile_q  <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			current_q  <= '0;
			last_tgt_q <= '0;
			done_q     <= 1'b0;
			applied_q  <= '0;
			m_valid_q  <= 1'b0;
			cmp_vld_q  <= 1'b0;
		end else begin
			// ST_OUT handles the result register itself
			if (m_valid_q && m_tready && state_q != ST_OUT) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser;
						ft_q    <= s_tdata[FT_W-1:0];
						tgt_q   <= s_tdata[FT_W+FPS_W-1:FT_W];
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					res_changed_q <= 1'b0;
					res_fps_q     <= '0;
					res_valid_q   <= 1'b0;
					res_oor_q     <= 1'b0;
					res_met_q     <= 1'b0;
					state_q       <= ST_OUT;
					if (cmd_q == CMD_FRAME) begin
						if (!done_q && !enable_q) begin
							// frame ignored before profiling is armed
						end else if (!done_q && profile_q >= n_eff) begin
							// profiling ends; this frame is discarded
							done_q        <= 1'b1;
							profile_q     <= '0;
							count_q       <= '0;
							sum_q         <= '0;
							applied_q     <= '0;
							res_changed_q <= 1'b1;
						end else if (win_end) begin
							dsh_q   <= {sum_new, {FPS_W{1'b0}}};
							sum_q   <= '0;
							count_q <= '0;
							state_q <= ST_MUL;
						end else begin
							sum_q   <= sum_new;
							count_q <= count_q + SPL_W'(1);
						end
					end else if (current_q != '0 && tgt_q != last_tgt_q) begin
						retune_q  <= cur_err > threshold_q;
						scan_q    <= '0;
						cmp_vld_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_MUL: begin
					rem_q   <= prod;
					quo_q   <= '0;
					step_q  <= 5'(FPS_W);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// one restoring-divide step per cycle, quotient MSB first
					if (div_ge) begin
						rem_q <= rem_q - dsh_q[NUM_W-1:0];
					end
					quo_q <= {quo_q[QUO_W-2:0], div_ge};
					dsh_q <= dsh_q >> 1;
					step_q <= step_q - 5'd1;
					if (step_q == '0) begin
						state_q <= ST_DIVEND;
					end
				end
				ST_DIVEND: begin
					res_fps_q   <= fps_div;
					res_valid_q <= 1'b1;
					if (!done_q) begin
						profile_q <= profile_q + CW'(1);
						if ((profile_q + CW'(1)) < n_eff) begin
							applied_q     <= IW'(profile_q + CW'(1));
							res_changed_q <= 1'b1;
						end
					end else begin
						current_q <= fps_div;
					end
					state_q <= ST_OUT;
				end
				ST_SCAN, ST_SCANEND: begin
					// issue one table read, compare the entry read last cycle
					if (state_q == ST_SCAN) begin
						cmp_idx_q <= scan_q;
						cmp_vld_q <= 1'b1;
						scan_q    <= scan_q + IW'(1);
						if (scan_q == n_last) begin
							state_q <= ST_SCANEND;
						end
					end else begin
						cmp_vld_q <= 1'b0;
						state_q   <= ST_DECIDE;
					end
					if (cmp_vld_q) begin
						if (cmp_idx_q == '0) begin
							min_err_q <= scan_err;
							best_q    <= '0;
							if (tgt_q > rd_q) begin
								res_oor_q <= 1'b1;
							end
						end else if (scan_err < min_err_q) begin
							min_err_q <= scan_err;
							best_q    <= cmp_idx_q;
						end
						if (cmp_idx_q == n_last && tgt_q < rd_q) begin
							res_oor_q <= 1'b1;
						end
					end
				end
				ST_DECIDE: begin
					if (retune_q) begin
						applied_q     <= best_q;
						res_changed_q <= 1'b1;
						last_tgt_q    <= tgt_q;
					end else begin
						res_met_q <= 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// load the result register once it is free
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {4'b0, res_met_q, res_oor_q, done_q, res_valid_q,
							res_fps_q, res_changed_q, LVL_W'(applied_q)};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for profiled_fps_frequency_selector
// Profiles a table of level rates through the input stream, then runs mixed
// frame and target traffic under random source gaps and sink stalls. Each
// result is compared field by field with a cycle-free governor model kept
// in this file.
// ----------------------------------------------------------------------------

module tb_top;
	import pfs_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int ACTIVE_GOAL = 1800;

	// Result fields as packed in m_tdata, lowest bit last
	typedef struct packed {
		logic             target_met;
		logic             target_out_of_range;
		logic             profiling_done;
		logic             fps_valid;
		logic [FPS_W-1:0] fps_value;
		logic             freq_changed;
		logic [LVL_W-1:0] freq_level;
	} gov_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [47:0]       s_tdata = '0;   // [23:0] frame_time_us, [41:24] target_fps
	logic              s_tuser = 1'b0; // [0] command
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;        // [4:0] freq_level, [5] freq_changed,
	                                   // [23:6] fps_value, [24] fps_valid,
	                                   // [25] profiling_done,
	                                   // [26] target_out_of_range, [27] target_met
	logic              cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [FPS_W-1:0]  cfg_wdata = '0;

	profiled_fps_frequency_selector #(
		.LEVELS(LEVELS_DEF)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Governor model state
	logic [FPS_W-1:0]  rate_table [LEVELS_DEF];
	int unsigned       prof_lvl = 0;
	int unsigned       sample_cnt = 0;
	longint unsigned   frame_sum = 0;
	logic [FPS_W-1:0]  cur_rate = '0;
	logic [FPS_W-1:0]  retune_target = '0;
	bit                prof_done = 0;
	logic [LVL_W-1:0]  level_now = '0;
	int unsigned       filled_levels = 0;

	// Model copy of the registers
	bit                cfg_enable = 0;
	int unsigned       cfg_samples = SAMPLES_RST;
	int unsigned       cfg_levels = NUM_LVL_RST;
	int unsigned       cfg_threshold = THRESHOLD_RST;

	gov_result_t       expected_results [$];
	int                errors = 0;
	int                active_items = 0;
	int                cycle_count = 0;
	int                src_max_gap = 11;
	int                sink_max_gap = 11;
	int                sink_hold = 0;

	function automatic int unsigned window_samples();
		return (cfg_samples == 0) ? 1 : cfg_samples;
	endfunction

	function automatic int unsigned active_levels();
		int unsigned n;
		n = (cfg_levels == 0) ? 1 : cfg_levels;
		if (n > LEVELS_DEF) n = LEVELS_DEF;
		return n;
	endfunction

	function automatic int unsigned abs_diff(input int unsigned a, input int unsigned b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [FPS_W-1:0] clamp_rate(input int v);
		if (v < 0) return '0;
		if (v > int'(FPS_MAX)) return FPS_MAX;
		return FPS_W'(v);
	endfunction

	// Add one frame time; returns 1 with the Q8 rate when the window closes
	function automatic bit close_window(input logic [FT_W-1:0] ft,
	                                    output logic [FPS_W-1:0] rate);
		longint unsigned s, q;
		s = window_samples();
		rate = '0;
		frame_sum = frame_sum + ft;
		if (frame_sum > SUM_MAX) frame_sum = SUM_MAX;
		if (sample_cnt + 1 >= s) begin
			if (frame_sum == 0) begin
				q = FPS_MAX;
			end else begin
				q = (s * longint'(Q8_SCALE)) / frame_sum;
				if (q > FPS_MAX) q = FPS_MAX;
			end
			rate = FPS_W'(q);
			frame_sum = 0;
			sample_cnt = 0;
			return 1;
		end
		sample_cnt++;
		return 0;
	endfunction

	// Expected result of one accepted item; active is 0 when the item is ignored
	function automatic gov_result_t predict_governor(input logic cmd,
	                                                 input logic [FT_W-1:0] ft,
	                                                 input logic [FPS_W-1:0] tgt,
	                                                 output bit active);
		gov_result_t r;
		logic [FPS_W-1:0] rate;
		int unsigned n, best, min_err, e;
		r = '0;
		active = 1;
		n = active_levels();
		if (cmd == CMD_FRAME) begin
			if (!prof_done) begin
				if (!cfg_enable) begin
					active = 0;
				end else if (prof_lvl < n) begin
					if (close_window(ft, rate)) begin
						r.fps_valid = 1'b1;
						r.fps_value = rate;
						rate_table[prof_lvl] = rate;
						prof_lvl++;
						if (prof_lvl > filled_levels) filled_levels = prof_lvl;
						// the last measured level keeps the applied level
						if (prof_lvl < n) begin
							level_now = LVL_W'(prof_lvl);
							r.freq_changed = 1'b1;
						end
					end
				end else begin
					// frame after the last level: discarded, back to level 0
					prof_done = 1;
					prof_lvl = 0;
					sample_cnt = 0;
					frame_sum = 0;
					level_now = '0;
					r.freq_changed = 1'b1;
				end
			end else if (close_window(ft, rate)) begin
				r.fps_valid = 1'b1;
				r.fps_value = rate;
				cur_rate = rate;
			end
		end else if (cur_rate != 0 && tgt != retune_target) begin
			if (tgt > rate_table[0] || tgt < rate_table[n-1])
				r.target_out_of_range = 1'b1;
			if (abs_diff(tgt, cur_rate) > cfg_threshold) begin
				// nearest profiled rate, first one wins on a tie
				best = 0;
				min_err = abs_diff(tgt, rate_table[0]);
				for (int i = 1; i < n; i++) begin
					e = abs_diff(tgt, rate_table[i]);
					if (e < min_err) begin
						min_err = e;
						best = i;
					end
				end
				level_now = LVL_W'(best);
				r.freq_changed = 1'b1;
				retune_target = tgt;
			end else begin
				r.target_met = 1'b1;
			end
		end else begin
			active = 0;
		end
		r.freq_level = level_now;
		r.profiling_done = prof_done;
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
	                                    input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Result checker and sink back-pressure
	always @(posedge clk) begin
		gov_result_t got, want;
		if (m_tvalid && m_tready) begin
			got = gov_result_t'(m_tdata[27:0]);
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("freq_level", want.freq_level, got.freq_level);
				check_field("freq_changed", want.freq_changed, got.freq_changed);
				check_field("fps_value", want.fps_value, got.fps_value);
				check_field("fps_valid", want.fps_valid, got.fps_valid);
				check_field("profiling_done", want.profiling_done, got.profiling_done);
				check_field("target_out_of_range", want.target_out_of_range,
				            got.target_out_of_range);
				check_field("target_met", want.target_met, got.target_met);
			end
			sink_hold = $urandom_range(0, sink_max_gap);
		end else if (sink_hold > 0) begin
			sink_hold = sink_hold - 1;
		end
		m_tready <= (sink_hold == 0);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("profiled_fps_frequency_selector test failed");
			$finish;
		end
	end

	// One input transfer after a random gap; predicts at acceptance
	task automatic send_item(input logic cmd, input logic [FT_W-1:0] ft,
	                         input logic [FPS_W-1:0] tgt);
		int gap;
		bit active;
		gap = $urandom_range(0, src_max_gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'b0, tgt, ft};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(predict_governor(cmd, ft, tgt, active));
		if (active) active_items++;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [FPS_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (addr)
			CFG_ENABLE:    cfg_enable = value[0];
			CFG_SAMPLES:   cfg_samples = value[SPL_W-1:0];
			CFG_NUM_LVL:   cfg_levels = value[NLV_W-1:0];
			CFG_THRESHOLD: cfg_threshold = value;
			default: ;
		endcase
	endtask

	task automatic pick_idling();
		src_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 11;
		sink_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 11;
	endtask

	// Mostly video-like frame times, some full-range and some tiny ones
	function automatic logic [FT_W-1:0] random_frame_time();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return FT_W'($urandom);
		if (pick == 1) return FT_W'($urandom_range(0, 100));
		return FT_W'($urandom_range(2000, 200000));
	endfunction

	// Reset defaults: profiling off, so frames and targets are ignored
	task automatic test_disabled_start();
		send_item(CMD_FRAME, '0, '1);
		send_item(CMD_FRAME, '1, '0);
		send_item(CMD_TARGET, '1, '1);
		send_item(CMD_TARGET, '0, '0);
	endtask

	// Build the rate table: corner rates first, then random windows
	task automatic test_profile_levels();
		wait_idle();
		write_reg(CFG_ENABLE, 1);
		write_reg(CFG_SAMPLES, 0);     // acts as one sample
		write_reg(CFG_NUM_LVL, 63);    // clipped to the level count
		send_item(CMD_FRAME, 24'd16667, '0);
		send_item(CMD_FRAME, '0, '0);  // zero sum gives the top rate
		send_item(CMD_FRAME, 24'd1, '0); // rate saturates
		send_item(CMD_FRAME, '1, '0);  // slowest possible frame
		// partial long window, then a shorter window closes on the old sum
		wait_idle();
		write_reg(CFG_SAMPLES, 1023);
		repeat (3) send_item(CMD_FRAME, random_frame_time(), FPS_W'($urandom));
		wait_idle();
		write_reg(CFG_SAMPLES, 2);
		send_item(CMD_FRAME, random_frame_time(), FPS_W'($urandom));
		// frames ignored while disabled
		wait_idle();
		write_reg(CFG_ENABLE, 0);
		send_item(CMD_FRAME, random_frame_time(), FPS_W'($urandom));
		send_item(CMD_TARGET, FT_W'($urandom), FPS_W'($urandom));
		wait_idle();
		write_reg(CFG_ENABLE, 1);
		write_reg(CFG_NUM_LVL, 32);
		while (prof_lvl < 20) begin
			wait_idle();
			pick_idling();
			write_reg(CFG_SAMPLES, FPS_W'($urandom_range(1, 4)));
			repeat ($urandom_range(1, 3) * window_samples()) begin
				if ($urandom_range(0, 6) == 0)
					send_item(CMD_TARGET, FT_W'($urandom), FPS_W'($urandom));
				send_item(CMD_FRAME, random_frame_time(), FPS_W'($urandom));
			end
		end
		// measure up to the last level, then shrink the count below it
		wait_idle();
		write_reg(CFG_NUM_LVL, 24);
		while (prof_lvl < 24)
			send_item(CMD_FRAME, random_frame_time(), FPS_W'($urandom));
		wait_idle();
		write_reg(CFG_NUM_LVL, 20);
		send_item(CMD_FRAME, random_frame_time(), FPS_W'($urandom));
	endtask

	// Target handling: out of range, repeated target, met, threshold extremes
	task automatic test_target_corners();
		wait_idle();
		write_reg(CFG_SAMPLES, 1);
		write_reg(CFG_THRESHOLD, 256);
		write_reg(CFG_NUM_LVL, FPS_W'(filled_levels));
		send_item(CMD_FRAME, 24'd16667, FPS_W'($urandom));
		send_item(CMD_TARGET, FT_W'($urandom), FPS_MAX);
		send_item(CMD_TARGET, FT_W'($urandom), FPS_MAX);  // same target, ignored
		send_item(CMD_TARGET, FT_W'($urandom), '0);
		send_item(CMD_TARGET, FT_W'($urandom), clamp_rate(int'(cur_rate) + 100));
		wait_idle();
		write_reg(CFG_THRESHOLD, 0);
		send_item(CMD_TARGET, FT_W'($urandom), clamp_rate(int'(cur_rate) + 1));
		wait_idle();
		write_reg(CFG_THRESHOLD, FPS_MAX);
		send_item(CMD_TARGET, FT_W'($urandom), FPS_W'($urandom));
		send_item(CMD_FRAME, '1, FPS_W'($urandom));
	endtask

	// Phases of random configuration and mixed frame/target traffic
	task automatic test_random_traffic();
		int unsigned pick, n, idx, phase_len;
		logic [FPS_W-1:0] tgt;
		while (active_items < ACTIVE_GOAL) begin
			wait_idle();
			pick_idling();
			write_reg(CFG_ENABLE, FPS_W'($urandom_range(0, 1)));
			pick = $urandom_range(0, 19);
			write_reg(CFG_SAMPLES,
			          FPS_W'((pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(1, 4)));
			write_reg(CFG_NUM_LVL, FPS_W'($urandom_range(0, filled_levels)));
			pick = $urandom_range(0, 9);
			write_reg(CFG_THRESHOLD,
			          (pick == 0) ? FPS_W'(0) : (pick == 1) ? FPS_MAX :
			          FPS_W'($urandom_range(0, 4000)));
			n = active_levels();
			phase_len = $urandom_range(20, 80);
			repeat (phase_len) begin
				if ($urandom_range(0, 99) < 55) begin
					send_item(CMD_FRAME, random_frame_time(), FPS_W'($urandom));
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 30) begin
						idx = $urandom_range(0, n - 1);
						tgt = clamp_rate(int'(rate_table[idx]) + int'($urandom_range(0, 1024)) - 512);
					end else if (pick < 55) begin
						tgt = clamp_rate(int'(cur_rate) - int'(cfg_threshold) - 50
						                 + int'($urandom_range(0, 2 * cfg_threshold + 100)));
					end else if (pick < 70) begin
						tgt = retune_target;
					end else if (pick < 85) begin
						tgt = FPS_W'($urandom);
					end else begin
						tgt = FPS_W'($urandom_range(0, 140000));
					end
					send_item(CMD_TARGET, FT_W'($urandom), tgt);
				end
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled_start();
		test_profile_levels();
		test_target_corners();
		test_random_traffic();
		wait_idle();
		repeat (64) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("profiled_fps_frequency_selector test passed");
		end else begin
			$display("profiled_fps_frequency_selector test failed");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/pfs_pkg.sv
hw/rtl/profiled_fps_frequency_selector.sv
bench/tb_top.sv
